>>> src/gke_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gamepad keystroke event generator - shared definitions
// Poll and result layouts, status and key codes, stick direction decode.
// ----------------------------------------------------------------------------
package gke_pkg;

  localparam int unsigned POLL_W      = 105;
  localparam int unsigned IN_TDATA_W  = 112;
  localparam int unsigned RES_W       = 17;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned CFG_DATA_W  = 15;

  localparam logic [STATUS_W-1:0] ST_EVENT   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADIDX  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTCONN = 2'd3;

  localparam logic CFG_STICK_THR = 1'b0;
  localparam logic CFG_TRIG_THR  = 1'b1;

  localparam logic [14:0] STICK_THR_RST = 15'd20000;
  localparam logic [7:0]  TRIG_THR_RST  = 8'd30;

  localparam logic [7:0]  PAD_ANY        = 8'hFF;
  localparam logic [7:0]  VK_PAGE        = 8'h58;
  localparam logic [15:0] VK_LTRIG       = 16'h5806;
  localparam logic [15:0] VK_RTRIG       = 16'h5807;
  localparam logic [15:0] VK_LSTICK_BASE = 16'h5820;
  localparam logic [15:0] VK_RSTICK_BASE = 16'h5830;
  localparam logic [15:0] BTN_TRACKED    = 16'hF3FF;

  localparam logic [1:0] AX_CENTER = 2'd0;
  localparam logic [1:0] AX_LOW    = 2'd1;
  localparam logic [1:0] AX_HIGH   = 2'd2;

  // lowest bits first: pad_index at bit 0
  typedef struct packed {
    logic signed [15:0] right_y;
    logic signed [15:0] right_x;
    logic signed [15:0] left_y;
    logic signed [15:0] left_x;
    logic        [7:0]  right_trigger;
    logic        [7:0]  left_trigger;
    logic        [15:0] buttons;
    logic               pad_connected;
    logic        [7:0]  pad_index;
  } poll_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                key_up;
    logic [15:0]         virtual_key;
  } result_t;

  function automatic logic [15:0] button_vk(input logic [3:0] sel);
    logic [15:0] vk;
    unique case (sel)
      4'd0:    vk = 16'h5810;
      4'd1:    vk = 16'h5811;
      4'd2:    vk = 16'h5812;
      4'd3:    vk = 16'h5813;
      4'd4:    vk = 16'h5814;
      4'd5:    vk = 16'h5815;
      4'd6:    vk = 16'h5816;
      4'd7:    vk = 16'h5817;
      4'd8:    vk = 16'h5804;
      4'd9:    vk = 16'h5805;
      4'd12:   vk = 16'h5800;
      4'd13:   vk = 16'h5801;
      4'd14:   vk = 16'h5802;
      4'd15:   vk = 16'h5803;
      default: vk = 16'h0000;
    endcase
    return vk;
  endfunction

  function automatic logic [1:0] axis_state(input logic signed [15:0] v,
                                            input logic [14:0] thr);
    logic signed [16:0] vx;
    logic signed [16:0] pos;
    logic signed [16:0] neg;
    logic [1:0]         st;
    vx  = {v[15], v};
    pos = signed'({2'b00, thr});
    neg = -pos;
    if (vx > pos) begin
      st = AX_HIGH;
    end else if (vx < neg) begin
      st = AX_LOW;
    end else begin
      st = AX_CENTER;
    end
    return st;
  endfunction

  // {active, direction offset}
  function automatic logic [3:0] stick_code(input logic signed [15:0] x,
                                            input logic signed [15:0] y,
                                            input logic [14:0] thr);
    logic [1:0] xs;
    logic [1:0] ys;
    logic [2:0] offs;
    xs = axis_state(x, thr);
    ys = axis_state(y, thr);
    unique case ({ys, xs})
      {AX_CENTER, AX_LOW}:  offs = 3'd3;
      {AX_CENTER, AX_HIGH}: offs = 3'd2;
      {AX_LOW, AX_CENTER}:  offs = 3'd1;
      {AX_LOW, AX_LOW}:     offs = 3'd7;
      {AX_LOW, AX_HIGH}:    offs = 3'd6;
      {AX_HIGH, AX_CENTER}: offs = 3'd0;
      {AX_HIGH, AX_LOW}:    offs = 3'd4;
      {AX_HIGH, AX_HIGH}:   offs = 3'd5;
      default:              offs = 3'd0;
    endcase
    return {(xs != AX_CENTER) || (ys != AX_CENTER), offs};
  endfunction

endpackage

>>> src/gke_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gamepad keystroke event generator - input register
// Holds one poll transaction until the event logic takes it.
// ----------------------------------------------------------------------------
module gke_in_reg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_tvalid_i,
  output logic                              s_tready_o,
  input  logic [gke_pkg::IN_TDATA_W-1:0]    s_tdata_i,
  output logic                              poll_valid_o,
  output gke_pkg::poll_t                    poll_o,
  input  logic                              poll_take_i
);

  logic           valid_q;
  gke_pkg::poll_t poll_q;

  assign s_tready_o   = !valid_q || poll_take_i;
  assign poll_valid_o = valid_q;
  assign poll_o       = poll_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_tready_o) begin
      valid_q <= s_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tready_o && s_tvalid_i) begin
      poll_q <= gke_pkg::poll_t'(s_tdata_i[gke_pkg::POLL_W-1:0]);
    end
  end

endmodule

>>> src/gke_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gamepad keystroke event generator - event logic
// Threshold registers, last reported pad state and the priority event decode.
// ----------------------------------------------------------------------------
module gke_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [gke_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  gke_pkg::poll_t                   poll_i,
  input  logic                             fire_i,
  output gke_pkg::result_t                 result_o
);

  logic [14:0]        stick_thr_q;
  logic [7:0]         trig_thr_q;

  logic [15:0]        last_btn_q, last_btn_d;
  logic [7:0]         last_lt_q, last_lt_d;
  logic [7:0]         last_rt_q, last_rt_d;
  logic signed [15:0] last_lx_q, last_lx_d;
  logic signed [15:0] last_ly_q, last_ly_d;
  logic signed [15:0] last_rx_q, last_rx_d;
  logic signed [15:0] last_ry_q, last_ry_d;

  logic [15:0]        btn_diff;
  logic               btn_hit;
  logic [3:0]         btn_sel;
  logic               bad_idx;
  logic               not_conn;
  logic               lt_on, lt_was, rt_on, rt_was;
  logic [3:0]         lcur, lold, rcur, rold;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stick_thr_q <= gke_pkg::STICK_THR_RST;
      trig_thr_q  <= gke_pkg::TRIG_THR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gke_pkg::CFG_STICK_THR: stick_thr_q <= cfg_data_i;
        gke_pkg::CFG_TRIG_THR:  trig_thr_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign btn_diff = (poll_i.buttons ^ last_btn_q) & gke_pkg::BTN_TRACKED;

  always_comb begin
    btn_hit = 1'b0;
    btn_sel = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (btn_diff[i]) begin
        btn_hit = 1'b1;
        btn_sel = 4'(i);
      end
    end
  end

  assign bad_idx  = (poll_i.pad_index[7:2] != 6'd0) && (poll_i.pad_index != gke_pkg::PAD_ANY);
  assign not_conn = !((poll_i.pad_index == 8'd0) || (poll_i.pad_index == gke_pkg::PAD_ANY))
                    || !poll_i.pad_connected;

  assign lt_on  = poll_i.left_trigger > trig_thr_q;
  assign lt_was = last_lt_q > trig_thr_q;
  assign rt_on  = poll_i.right_trigger > trig_thr_q;
  assign rt_was = last_rt_q > trig_thr_q;

  assign lcur = gke_pkg::stick_code(poll_i.left_x, poll_i.left_y, stick_thr_q);
  assign lold = gke_pkg::stick_code(last_lx_q, last_ly_q, stick_thr_q);
  assign rcur = gke_pkg::stick_code(poll_i.right_x, poll_i.right_y, stick_thr_q);
  assign rold = gke_pkg::stick_code(last_rx_q, last_ry_q, stick_thr_q);

  always_comb begin
    result_o.status      = gke_pkg::ST_EMPTY;
    result_o.virtual_key = 16'h0000;
    result_o.key_up      = 1'b0;
    last_btn_d = last_btn_q;
    last_lt_d  = last_lt_q;
    last_rt_d  = last_rt_q;
    last_lx_d  = last_lx_q;
    last_ly_d  = last_ly_q;
    last_rx_d  = last_rx_q;
    last_ry_d  = last_ry_q;
    priority if (bad_idx) begin
      result_o.status = gke_pkg::ST_BADIDX;
    end else if (not_conn) begin
      result_o.status = gke_pkg::ST_NOTCONN;
    end else if (btn_hit) begin
      result_o.status      = gke_pkg::ST_EVENT;
      result_o.virtual_key = gke_pkg::button_vk(btn_sel);
      result_o.key_up      = !poll_i.buttons[btn_sel];
      last_btn_d[btn_sel]  = poll_i.buttons[btn_sel];
    end else if (lt_on != lt_was) begin
      result_o.status      = gke_pkg::ST_EVENT;
      result_o.virtual_key = gke_pkg::VK_LTRIG;
      result_o.key_up      = !lt_on;
      last_lt_d            = poll_i.left_trigger;
    end else if (rt_on != rt_was) begin
      result_o.status      = gke_pkg::ST_EVENT;
      result_o.virtual_key = gke_pkg::VK_RTRIG;
      result_o.key_up      = !rt_on;
      last_rt_d            = poll_i.right_trigger;
    end else if (lcur != lold) begin
      result_o.status = gke_pkg::ST_EVENT;
      if (lold[3]) begin
        result_o.virtual_key = gke_pkg::VK_LSTICK_BASE + {13'd0, lold[2:0]};
        result_o.key_up      = 1'b1;
        last_lx_d            = 16'sd0;
        last_ly_d            = 16'sd0;
      end else begin
        result_o.virtual_key = gke_pkg::VK_LSTICK_BASE + {13'd0, lcur[2:0]};
        last_lx_d            = poll_i.left_x;
        last_ly_d            = poll_i.left_y;
      end
    end else begin
      last_lx_d = poll_i.left_x;
      last_ly_d = poll_i.left_y;
      last_rx_d = poll_i.right_x;
      last_ry_d = poll_i.right_y;
      if (rcur != rold) begin
        result_o.status = gke_pkg::ST_EVENT;
        if (rold[3]) begin
          result_o.virtual_key = gke_pkg::VK_RSTICK_BASE + {13'd0, rold[2:0]};
          result_o.key_up      = 1'b1;
          last_rx_d            = 16'sd0;
          last_ry_d            = 16'sd0;
        end else begin
          result_o.virtual_key = gke_pkg::VK_RSTICK_BASE + {13'd0, rcur[2:0]};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_btn_q <= '0;
      last_lt_q  <= '0;
      last_rt_q  <= '0;
      last_lx_q  <= '0;
      last_ly_q  <= '0;
      last_rx_q  <= '0;
      last_ry_q  <= '0;
    end else if (fire_i) begin
      last_btn_q <= last_btn_d;
      last_lt_q  <= last_lt_d;
      last_rt_q  <= last_rt_d;
      last_lx_q  <= last_lx_d;
      last_ly_q  <= last_ly_d;
      last_rx_q  <= last_rx_d;
      last_ry_q  <= last_ry_d;
    end
  end

endmodule

>>> src/gke_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gamepad keystroke event generator - result register
// Holds one result transaction until the downstream side takes it.
// ----------------------------------------------------------------------------
module gke_out_reg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               res_valid_i,
  output logic                               res_ready_o,
  input  gke_pkg::result_t                   result_i,
  output logic                               m_tvalid_o,
  input  logic                               m_tready_i,
  output logic [gke_pkg::OUT_TDATA_W-1:0]    m_tdata_o,
  output logic [gke_pkg::STATUS_W-1:0]       m_tuser_o
);

  localparam int unsigned PAD_W = gke_pkg::OUT_TDATA_W - gke_pkg::RES_W;

  logic             valid_q;
  gke_pkg::result_t res_q;

  assign res_ready_o = !valid_q || m_tready_i;
  assign m_tvalid_o  = valid_q;
  assign m_tdata_o   = {{PAD_W{1'b0}}, res_q.key_up, res_q.virtual_key};
  assign m_tuser_o   = res_q.status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_ready_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_o && res_valid_i) begin
      res_q <= result_i;
    end
  end

endmodule

>>> src/gamepad_keystroke_event_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gamepad keystroke event generator
// Turns pad polls into at most one key press or release per poll.
// ----------------------------------------------------------------------------
// Channel  | Direction | Contents
// s_*      | in        | tdata: pad_index, pad_connected, buttons_now, left/right
//          |           |        trigger, left_x, left_y, right_x, right_y
// m_*      | out       | tdata: virtual_key, key_up; tuser: status
// cfg_*    | in        | 0 stick_threshold, 1 trigger_threshold
//
// One poll per cycle while m_tready_i is high; an accepted poll is held in the
// input register, passes the event decode, and its result is held in the result register.
// Reset clears the thresholds to 20000 and 30 and the last pad state to zero.
// A stalled m_tready_i holds the result; one more poll waits in the input
// register before s_tready_o drops.
// ----------------------------------------------------------------------------
module gamepad_keystroke_event_generator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_tvalid_i,
  output logic                             s_tready_o,
  // [7:0] pad_index, [8] pad_connected, [24:9] buttons_now,
  // [32:25] left_trigger_now, [40:33] right_trigger_now, [56:41] left_x_now,
  // [72:57] left_y_now, [88:73] right_x_now, [104:89] right_y_now, rest zero
  input  logic [gke_pkg::IN_TDATA_W-1:0]   s_tdata_i,
  output logic                             m_tvalid_o,
  input  logic                             m_tready_i,
  // [15:0] virtual_key, [16] key_up, rest zero
  output logic [gke_pkg::OUT_TDATA_W-1:0]  m_tdata_o,
  // [1:0] status
  output logic [gke_pkg::STATUS_W-1:0]     m_tuser_o,
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [gke_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  logic             poll_valid;
  gke_pkg::poll_t   poll;
  logic             res_ready;
  logic             fire;
  gke_pkg::result_t result;

  assign fire = poll_valid && res_ready;

  gke_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid_i),
    .s_tready_o   (s_tready_o),
    .s_tdata_i    (s_tdata_i),
    .poll_valid_o (poll_valid),
    .poll_o       (poll),
    .poll_take_i  (fire)
  );

  gke_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .poll_i     (poll),
    .fire_i     (fire),
    .result_o   (result)
  );

  gke_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (poll_valid),
    .res_ready_o (res_ready),
    .result_i    (result),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tuser_o   (m_tuser_o)
  );

endmodule

>>> src/gke_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gamepad keystroke event generator - port checker
// Watches the poll handshake and the result channel of the top level over time.
// ----------------------------------------------------------------------------
module gke_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_tvalid_i,
  input  logic                             s_tready_o,
  input  logic                             m_tvalid_o,
  input  logic                             m_tready_i,
  input  logic [gke_pkg::OUT_TDATA_W-1:0]  m_tdata_o,
  input  logic [gke_pkg::STATUS_W-1:0]     m_tuser_o
);

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !m_tvalid_o)
    else $error("result valid during reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o) && $stable(m_tuser_o))
    else $error("stalled result transaction changed");

  a_no_event_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && (m_tuser_o != gke_pkg::ST_EVENT) |-> m_tdata_o == '0)
    else $error("key fields set without an event");

  a_event_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && (m_tuser_o == gke_pkg::ST_EVENT) |-> m_tdata_o[15:8] == gke_pkg::VK_PAGE)
    else $error("event key code outside the pad key page");

  a_accept_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o |-> ##2 m_tvalid_o)
    else $error("accepted poll transaction gave no result");

endmodule

bind gamepad_keystroke_event_generator gke_checker u_gke_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_tvalid_i),
  .s_tready_o (s_tready_o),
  .m_tvalid_o (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_o  (m_tdata_o),
  .m_tuser_o  (m_tuser_o)
);
